/* src/lodg_pkg.sv */
// shared types, codes and constants of the log-odds occupancy grid block
`timescale 1ns / 1ps

package lodg_pkg;

  // default grid size
  localparam int GRID_ROWS_DEF = 8;
  localparam int GRID_COLS_DEF = 8;

  // cell value limits and report limit
  localparam int CELL_MAX    = 127;
  localparam int MAX_REPORTS = 64;

  // register reset values
  localparam logic signed [7:0] OCC_INC_RST  = 8'sd16;
  localparam logic signed [7:0] FREE_INC_RST = -8'sd8;
  localparam logic [6:0]        THR_RST      = 7'd58;
  localparam logic [6:0]        DECAY_RST    = 7'd5;

  // input commands
  typedef enum logic [2:0] {
    CMD_HIT   = 3'd0,
    CMD_MISS  = 3'd1,
    CMD_FREE  = 3'd2,
    CMD_DECAY = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_OCC_INC  = 2'd0,
    CFG_FREE_INC = 2'd1,
    CFG_THR      = 2'd2,
    CFG_DECAY    = 2'd3
  } cfg_e;

  // cell classes
  typedef enum logic [1:0] {
    CLS_UNKNOWN  = 2'd0,
    CLS_OCCUPIED = 2'd1,
    CLS_FREE     = 2'd2
  } cls_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_NEXT,
    ST_RD,
    ST_WB,
    ST_FLUSH
  } state_t;

  // which cell source the sequencer works on
  typedef enum logic [1:0] {
    PH_WALK,
    PH_TARGET,
    PH_ROVER,
    PH_DECAY
  } phase_t;

  // line walker control
  typedef struct packed {
    logic load;
    logic step;
  } walk_ctrl_t;

  // operation for the cell update unit
  typedef struct packed {
    logic              decay;
    logic signed [7:0] delta;
  } cell_op_t;

  // one result item
  typedef struct packed {
    logic [5:0]        row;
    logic [5:0]        col;
    logic signed [7:0] value;
    logic [1:0]        cls;
    logic              changed;
    logic              last;
  } report_t;

endpackage

/* src/lodg_ram.sv */
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module lodg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/lodg_walker.sv */
// bresenham line walker, one cell per step
`timescale 1ns / 1ps

module lodg_walker (
  input  logic                clk,
  input  lodg_pkg::walk_ctrl_t ctrl,
  input  logic [7:0]          x0,
  input  logic [7:0]          y0,
  input  logic [7:0]          x1,
  input  logic [7:0]          y1,
  output logic [7:0]          x,
  output logic [7:0]          y,
  output logic                at_end
);

  logic [7:0]         x_end;
  logic [7:0]         y_end;
  logic [7:0]         dx;
  logic [7:0]         dy_mag;
  logic               sx_neg;
  logic               sy_neg;
  logic signed [11:0] err;

  logic [7:0]         dx_init;
  logic [7:0]         dy_init;
  logic signed [12:0] e2;
  logic signed [12:0] dx_s;
  logic signed [12:0] dy_s;
  logic               step_x;
  logic               step_y;
  logic signed [11:0] err_next;

  // setup distances
  assign dx_init = (x1 > x0) ? (x1 - x0) : (x0 - x1);
  assign dy_init = (y1 > y0) ? (y1 - y0) : (y0 - y1);

  // step decision from doubled error
  assign e2     = {err, 1'b0};
  assign dx_s   = 13'(signed'({1'b0, dx}));
  assign dy_s   = -13'(signed'({1'b0, dy_mag}));
  assign step_x = (e2 >= dy_s);
  assign step_y = (e2 <= dx_s);

  always_comb begin
    err_next = err;
    if (step_x) begin
      err_next = err_next - 12'(signed'({1'b0, dy_mag}));
    end
    if (step_y) begin
      err_next = err_next + 12'(signed'({1'b0, dx}));
    end
  end

  assign at_end = (x == x_end) && (y == y_end);

  // walker registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x      <= x0;
      y      <= y0;
      x_end  <= x1;
      y_end  <= y1;
      dx     <= dx_init;
      dy_mag <= dy_init;
      sx_neg <= !(x0 < x1);
      sy_neg <= !(y0 < y1);
      err    <= 12'(signed'({1'b0, dx_init})) - 12'(signed'({1'b0, dy_init}));
    end else if (ctrl.step) begin
      err <= err_next;
      if (step_x) begin
        x <= sx_neg ? (x - 8'd1) : (x + 8'd1);
      end
      if (step_y) begin
        y <= sy_neg ? (y - 8'd1) : (y + 8'd1);
      end
    end
  end

endmodule

/* src/lodg_cell_unit.sv */
// shared cell update unit: saturating add or decay, then class compare
`timescale 1ns / 1ps

module lodg_cell_unit (
  input  logic signed [7:0]  stored_value,
  input  lodg_pkg::cell_op_t op,
  input  logic [6:0]         thr,
  input  logic [6:0]         step,
  output logic signed [7:0]  updated_value,
  output logic [1:0]         new_cls,
  output logic               changed
);

  logic signed [8:0] v9;
  logic signed [8:0] d9;
  logic signed [8:0] st9;
  logic signed [8:0] sum;
  logic signed [8:0] sat;
  logic signed [8:0] dec;
  logic [1:0]        old_cls;

  function automatic logic [1:0] classify(input logic signed [8:0] v, input logic [6:0] t);
    logic signed [8:0] t9;
    t9 = signed'({2'b00, t});
    if (v > t9) begin
      classify = lodg_pkg::CLS_OCCUPIED;
    end else if (v < -t9) begin
      classify = lodg_pkg::CLS_FREE;
    end else begin
      classify = lodg_pkg::CLS_UNKNOWN;
    end
  endfunction

  assign v9  = {stored_value[7], stored_value};
  assign d9  = {op.delta[7], op.delta};
  assign st9 = signed'({2'b00, step});

  // saturating add
  assign sum = v9 + d9;
  always_comb begin
    if (sum > 9'(lodg_pkg::CELL_MAX)) begin
      sat = 9'(lodg_pkg::CELL_MAX);
    end else if (sum < -9'(lodg_pkg::CELL_MAX)) begin
      sat = -9'(lodg_pkg::CELL_MAX);
    end else begin
      sat = sum;
    end
  end

  // decay toward zero
  always_comb begin
    if (v9 > 9'sd0) begin
      dec = (v9 > st9) ? (v9 - st9) : 9'sd0;
    end else if (v9 < 9'sd0) begin
      dec = (v9 < -st9) ? (v9 + st9) : 9'sd0;
    end else begin
      dec = 9'sd0;
    end
  end

  assign updated_value = op.decay ? dec[7:0] : sat[7:0];
  assign old_cls       = classify(v9, thr);
  assign new_cls       = classify({updated_value[7], updated_value}, thr);
  assign changed       = (old_cls != new_cls);

endmodule

/* src/log_odds_occupancy_grid_ray_update_top.sv */
// log-odds occupancy grid with bresenham ray updates: sequencer and top level
// sequencing: a ray visits each walked in-grid cell in ST_NEXT, ST_RD and ST_WB, steps over off-grid
//   cells in ST_NEXT and, for a hit, handles the target the same way; decay reads and writes back every
//   cell, clear writes every cell; each command ends in ST_FLUSH, and output stalls can hold ST_WB and ST_FLUSH
// throughput: one command at a time; in_stall stays high until its last item is loaded
// reset: a clearing pass zeroes the grid, in_stall high
`timescale 1ns / 1ps

module log_odds_occupancy_grid_ray_update_top #(
  parameter int GRID_ROWS = lodg_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = lodg_pkg::GRID_COLS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  // commands
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        command,
  input  logic [7:0]        rover_col,
  input  logic [7:0]        rover_row,
  input  logic [7:0]        target_col,
  input  logic [7:0]        target_row,
  // results
  output logic              out_valid,
  input  logic              out_stall,
  output logic [5:0]        cell_row,
  output logic [5:0]        cell_col,
  output logic signed [7:0] cell_value,
  output logic [1:0]        cell_class,
  output logic              changed,
  output logic              last
);

  localparam int DEPTH = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(DEPTH);

  lodg_pkg::state_t state, state_next;
  lodg_pkg::phase_t phase;

  logic              is_hit;
  logic [7:0]        tgt_x, tgt_y, rov_x, rov_y;
  logic [5:0]        dec_row, dec_col;
  logic [AW-1:0]     clr_addr;
  logic              clr_reply;
  logic              grid_ready;
  logic signed [7:0] occ_inc, free_inc;
  logic [6:0]        cls_thr, dec_step;
  logic [6:0]        rep_cnt;
  lodg_pkg::report_t pend, out_reg;
  logic              pend_valid;

  // datapath wires
  logic [7:0]           w_x, w_y;
  logic                 w_end;
  lodg_pkg::walk_ctrl_t w_ctrl;
  logic [7:0]           cur_x, cur_y;
  logic                 cur_in_grid;
  logic                 rover_in_grid;
  logic [12:0]          addr_wide;
  logic [AW-1:0]        cell_addr;
  lodg_pkg::cell_op_t   cell_op;
  logic [7:0]           ram_rdata;
  logic signed [7:0]    unit_value;
  logic [1:0]           unit_cls;
  logic                 unit_changed;
  logic                 report;
  logic                 slot_free;
  logic                 commit;
  logic                 accept;
  logic                 clr_last;
  logic                 dec_last;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr;
  logic [7:0]           ram_wdata;
  lodg_pkg::report_t    new_rep;
  lodg_pkg::report_t    flush_rep;
  logic                 out_load;

  assign accept        = in_valid && !in_stall;
  assign in_stall      = (state != lodg_pkg::ST_IDLE);
  assign slot_free     = !out_valid || !out_stall;
  assign rover_in_grid = (rover_col < 8'(GRID_COLS)) && (rover_row < 8'(GRID_ROWS));
  assign clr_last      = (clr_addr == AW'(DEPTH - 1));
  assign dec_last      = (dec_row == 6'(GRID_ROWS - 1)) && (dec_col == 6'(GRID_COLS - 1));

  // current cell source
  always_comb begin
    case (phase)
      lodg_pkg::PH_WALK: begin
        cur_x = w_x;
        cur_y = w_y;
      end
      lodg_pkg::PH_TARGET: begin
        cur_x = tgt_x;
        cur_y = tgt_y;
      end
      lodg_pkg::PH_ROVER: begin
        cur_x = rov_x;
        cur_y = rov_y;
      end
      lodg_pkg::PH_DECAY: begin
        cur_x = {2'b00, dec_col};
        cur_y = {2'b00, dec_row};
      end
      default: begin
        cur_x = w_x;
        cur_y = w_y;
      end
    endcase
  end

  assign cur_in_grid = (cur_x < 8'(GRID_COLS)) && (cur_y < 8'(GRID_ROWS));
  assign addr_wide   = 13'(cur_y[5:0]) * 13'(GRID_COLS) + 13'(cur_x[5:0]);
  assign cell_addr   = addr_wide[AW-1:0];

  // cell operation by phase
  assign cell_op.decay = (phase == lodg_pkg::PH_DECAY);
  assign cell_op.delta = (phase == lodg_pkg::PH_TARGET) ? occ_inc : free_inc;

  // report bookkeeping
  assign report  = unit_changed && (rep_cnt < 7'(lodg_pkg::MAX_REPORTS));
  assign commit  = (state == lodg_pkg::ST_WB) && !(report && pend_valid && !slot_free);

  assign new_rep.row     = cur_y[5:0];
  assign new_rep.col     = cur_x[5:0];
  assign new_rep.value   = unit_value;
  assign new_rep.cls     = unit_cls;
  assign new_rep.changed = 1'b1;
  assign new_rep.last    = 1'b0;

  // final item of a command: the held report or a bare done item
  always_comb begin
    if (pend_valid) begin
      flush_rep = pend;
    end else begin
      flush_rep = '0;
    end
    flush_rep.last = 1'b1;
  end

  // output register loads on a report while one is held, or at flush
  assign out_load = (commit && report && pend_valid) ||
                    ((state == lodg_pkg::ST_FLUSH) && slot_free);

  lodg_walker u_walker (
    .clk    (clk),
    .ctrl   (w_ctrl),
    .x0     (rover_col),
    .y0     (rover_row),
    .x1     (target_col),
    .y1     (target_row),
    .x      (w_x),
    .y      (w_y),
    .at_end (w_end)
  );

  lodg_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cell_addr),
    .rdata (ram_rdata)
  );

  lodg_cell_unit u_cell (
    .stored_value  (signed'(ram_rdata)),
    .op            (cell_op),
    .thr           (cls_thr),
    .step          (dec_step),
    .updated_value (unit_value),
    .new_cls       (unit_cls),
    .changed       (unit_changed)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lodg_pkg::ST_INIT: begin
        if (clr_last) begin
          state_next = clr_reply ? lodg_pkg::ST_FLUSH : lodg_pkg::ST_IDLE;
        end
      end
      lodg_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (command)
            lodg_pkg::CMD_HIT: begin
              state_next = grid_ready ? lodg_pkg::ST_NEXT : lodg_pkg::ST_FLUSH;
            end
            lodg_pkg::CMD_MISS: begin
              state_next = (grid_ready && rover_in_grid) ? lodg_pkg::ST_NEXT
                                                         : lodg_pkg::ST_FLUSH;
            end
            lodg_pkg::CMD_FREE: begin
              state_next = (grid_ready && rover_in_grid) ? lodg_pkg::ST_RD
                                                         : lodg_pkg::ST_FLUSH;
            end
            lodg_pkg::CMD_DECAY: state_next = lodg_pkg::ST_RD;
            lodg_pkg::CMD_CLEAR: state_next = lodg_pkg::ST_INIT;
            default:             state_next = lodg_pkg::ST_FLUSH;
          endcase
        end
      end
      lodg_pkg::ST_NEXT: begin
        if (phase == lodg_pkg::PH_WALK) begin
          if (w_end) begin
            state_next = is_hit ? lodg_pkg::ST_NEXT : lodg_pkg::ST_FLUSH;
          end else if (cur_in_grid) begin
            state_next = lodg_pkg::ST_RD;
          end
        end else begin
          state_next = cur_in_grid ? lodg_pkg::ST_RD : lodg_pkg::ST_FLUSH;
        end
      end
      lodg_pkg::ST_RD: state_next = lodg_pkg::ST_WB;
      lodg_pkg::ST_WB: begin
        if (commit) begin
          case (phase)
            lodg_pkg::PH_WALK:  state_next = lodg_pkg::ST_NEXT;
            lodg_pkg::PH_DECAY: state_next = dec_last ? lodg_pkg::ST_FLUSH : lodg_pkg::ST_RD;
            default:            state_next = lodg_pkg::ST_FLUSH;
          endcase
        end
      end
      lodg_pkg::ST_FLUSH: begin
        if (slot_free) begin
          state_next = lodg_pkg::ST_IDLE;
        end
      end
      default: state_next = lodg_pkg::ST_INIT;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = cell_addr;
    ram_wdata   = unit_value;
    ram_re      = 1'b0;
    w_ctrl.load = 1'b0;
    w_ctrl.step = 1'b0;
    case (state)
      lodg_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = 8'd0;
      end
      lodg_pkg::ST_IDLE: begin
        w_ctrl.load = accept;
      end
      lodg_pkg::ST_NEXT: begin
        w_ctrl.step = (phase == lodg_pkg::PH_WALK) && !w_end && !cur_in_grid;
      end
      lodg_pkg::ST_RD: begin
        ram_re = 1'b1;
      end
      lodg_pkg::ST_WB: begin
        ram_we      = commit;
        w_ctrl.step = commit && (phase == lodg_pkg::PH_WALK);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lodg_pkg::ST_INIT;
      phase      <= lodg_pkg::PH_WALK;
      clr_addr   <= '0;
      clr_reply  <= 1'b0;
      grid_ready <= 1'b0;
      rep_cnt    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      is_hit     <= 1'b0;
      dec_row    <= '0;
      dec_col    <= '0;
    end else begin
      state <= state_next;

      // output register fills on load and drains when taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        lodg_pkg::ST_INIT: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_last && clr_reply) begin
            grid_ready <= 1'b1;
          end
        end
        lodg_pkg::ST_IDLE: begin
          if (accept) begin
            rep_cnt    <= '0;
            pend_valid <= 1'b0;
            is_hit     <= (command == lodg_pkg::CMD_HIT);
            dec_row    <= '0;
            dec_col    <= '0;
            clr_addr   <= '0;
            clr_reply  <= 1'b1;
            case (command)
              lodg_pkg::CMD_FREE:  phase <= lodg_pkg::PH_ROVER;
              lodg_pkg::CMD_DECAY: phase <= lodg_pkg::PH_DECAY;
              default:             phase <= lodg_pkg::PH_WALK;
            endcase
          end
        end
        lodg_pkg::ST_NEXT: begin
          if ((phase == lodg_pkg::PH_WALK) && w_end && is_hit) begin
            phase <= lodg_pkg::PH_TARGET;
          end
        end
        lodg_pkg::ST_WB: begin
          if (commit) begin
            if (report) begin
              rep_cnt    <= rep_cnt + 7'd1;
              pend_valid <= 1'b1;
            end
            if (phase == lodg_pkg::PH_DECAY) begin
              if (dec_col == 6'(GRID_COLS - 1)) begin
                dec_col <= '0;
                dec_row <= dec_row + 6'd1;
              end else begin
                dec_col <= dec_col + 6'd1;
              end
            end
          end
        end
        lodg_pkg::ST_FLUSH: begin
          if (slot_free) begin
            pend_valid <= 1'b0;
          end
        end
        default: begin
          clr_reply <= clr_reply;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      tgt_x <= target_col;
      tgt_y <= target_row;
      rov_x <= rover_col;
      rov_y <= rover_row;
    end
    if (commit && report) begin
      pend <= new_rep;
      if (pend_valid) begin
        out_reg <= pend;
      end
    end
    if ((state == lodg_pkg::ST_FLUSH) && slot_free) begin
      out_reg <= flush_rep;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      occ_inc  <= lodg_pkg::OCC_INC_RST;
      free_inc <= lodg_pkg::FREE_INC_RST;
      cls_thr  <= lodg_pkg::THR_RST;
      dec_step <= lodg_pkg::DECAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lodg_pkg::CFG_OCC_INC:  occ_inc  <= signed'(cfg_data);
        lodg_pkg::CFG_FREE_INC: free_inc <= signed'(cfg_data);
        lodg_pkg::CFG_THR:      cls_thr  <= cfg_data[6:0];
        lodg_pkg::CFG_DECAY:    dec_step <= cfg_data[6:0];
        default:                occ_inc  <= occ_inc;
      endcase
    end
  end

  assign cell_row   = out_reg.row;
  assign cell_col   = out_reg.col;
  assign cell_value = out_reg.value;
  assign cell_class = out_reg.cls;
  assign changed    = out_reg.changed;
  assign last       = out_reg.last;

`ifndef ASSERT_OFF
  // an accepted command keeps the input side closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input not stalled after accepting an item");

  // no report left over from an earlier command while idle
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !pend_valid)
    else $error("pending report while idle");

  // report count never runs past the limit, and a pending report was counted
  a_report_count: assert property (@(posedge clk) disable iff (rst)
    (rep_cnt <= 7'(lodg_pkg::MAX_REPORTS)) && (!pend_valid || (rep_cnt != 7'd0)))
    else $error("report count out of range");

  // the cell memory is never written while the output would lose a report
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (commit && report && pend_valid) |-> slot_free)
    else $error("result item overwritten");
`endif

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the log-odds occupancy grid ray update block
`timescale 1ns / 1ps

module tb_top;

  localparam int GRID_ROWS = lodg_pkg::GRID_ROWS_DEF;
  localparam int GRID_COLS = lodg_pkg::GRID_COLS_DEF;
  localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;
  // leave room for a full decay pass plus the issue and flush cycles
  localparam int SETTLE_CYCLES = 3 * GRID_CELLS + 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SHOW_LIMIT = 10;
  localparam int RANDOM_PHASES = 5;
  localparam int RANDOM_PER_PHASE = 16;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  typedef struct {
    logic [2:0] cmd;
    logic [7:0] rc;
    logic [7:0] rr;
    logic [7:0] tc;
    logic [7:0] tr;
  } grid_cmd_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // block ports
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = lodg_pkg::CFG_OCC_INC;
  logic [7:0]        cfg_data = 8'd0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        command = lodg_pkg::CMD_CLEAR;
  logic [7:0]        rover_col = 8'd0;
  logic [7:0]        rover_row = 8'd0;
  logic [7:0]        target_col = 8'd0;
  logic [7:0]        target_row = 8'd0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [5:0]        cell_row;
  logic [5:0]        cell_col;
  logic signed [7:0] cell_value;
  logic [1:0]        cell_class;
  logic              changed;
  logic              last;

  log_odds_occupancy_grid_ray_update_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .rover_col  (rover_col),
    .rover_row  (rover_row),
    .target_col (target_col),
    .target_row (target_row),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_row   (cell_row),
    .cell_col   (cell_col),
    .cell_value (cell_value),
    .cell_class (cell_class),
    .changed    (changed),
    .last       (last)
  );

  // shadow grid and registers
  logic signed [7:0] grid_q [GRID_CELLS];
  bit                grid_ready_q = 1'b0;
  logic signed [7:0] occ_inc_q = lodg_pkg::OCC_INC_RST;
  logic signed [7:0] free_inc_q = lodg_pkg::FREE_INC_RST;
  logic [6:0]        thr_q = lodg_pkg::THR_RST;
  logic [6:0]        decay_q = lodg_pkg::DECAY_RST;

  grid_cmd_t         cmd_pending_q [$];
  grid_cmd_t         cur_cmd;
  lodg_pkg::report_t cmd_reports [$];
  lodg_pkg::report_t report_exp_q [$];

  int send_idle_pct = 27;
  int recv_stall_pct = 76;
  int cycle_cnt = 0;
  int fail_cnt = 0;
  int cmds_accepted = 0;
  int reports_checked = 0;
  int cfg_writes = 0;

  initial begin
    foreach (grid_q[i]) grid_q[i] = 8'sd0;
  end

  // class of a log-odds value under the current threshold
  function automatic lodg_pkg::cls_e class_of(int v);
    if (v > int'(thr_q)) return lodg_pkg::CLS_OCCUPIED;
    if (v < -int'(thr_q)) return lodg_pkg::CLS_FREE;
    return lodg_pkg::CLS_UNKNOWN;
  endfunction

  function automatic bit on_grid(int col, int row);
    return col >= 0 && col < GRID_COLS && row >= 0 && row < GRID_ROWS;
  endfunction

  // store a cell and note a class change, up to the report limit
  function automatic void store_cell(int col, int row, int val);
    int                idx;
    lodg_pkg::cls_e    old_cls;
    lodg_pkg::cls_e    new_cls;
    lodg_pkg::report_t rep;
    idx = row * GRID_COLS + col;
    old_cls = class_of(int'(grid_q[idx]));
    new_cls = class_of(val);
    grid_q[idx] = 8'(val);
    if (old_cls != new_cls && cmd_reports.size() < lodg_pkg::MAX_REPORTS) begin
      rep.row = 6'(row);
      rep.col = 6'(col);
      rep.value = 8'(val);
      rep.cls = new_cls;
      rep.changed = 1'b1;
      rep.last = 1'b0;
      cmd_reports.push_back(rep);
    end
  endfunction

  // saturating add to one cell, off-grid cells skipped
  function automatic void add_log_odds(int col, int row, int delta);
    int v;
    if (!on_grid(col, row)) return;
    v = int'(grid_q[row * GRID_COLS + col]) + delta;
    if (v > lodg_pkg::CELL_MAX) v = lodg_pkg::CELL_MAX;
    if (v < -lodg_pkg::CELL_MAX) v = -lodg_pkg::CELL_MAX;
    store_cell(col, row, v);
  endfunction

  // line walk from rover toward target, target itself excluded
  function automatic void walk_ray_free(int x0, int y0, int x1, int y1);
    int dx;
    int dy;
    int sx;
    int sy;
    int err;
    int e2;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = -((y1 > y0) ? y1 - y0 : y0 - y1);
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = dx + dy;
    while (!(x0 == x1 && y0 == y1)) begin
      e2 = 2 * err;
      add_log_odds(x0, y0, int'(free_inc_q));
      if (e2 >= dy) begin
        err += dy;
        x0 += sx;
      end
      if (e2 <= dx) begin
        err += dx;
        y0 += sy;
      end
    end
  endfunction

  // move every nonzero cell toward zero, row by row
  function automatic void decay_grid();
    int v;
    int d;
    d = int'(decay_q);
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        v = int'(grid_q[r * GRID_COLS + c]);
        if (v > 0) store_cell(c, r, (v > d) ? v - d : 0);
        else if (v < 0) store_cell(c, r, (v < -d) ? v + d : 0);
      end
    end
  endfunction

  // expected reports of one accepted command
  function automatic void apply_grid_cmd(grid_cmd_t gc);
    lodg_pkg::report_t done_rep;
    cmd_reports.delete();
    case (gc.cmd)
      lodg_pkg::CMD_HIT: begin
        if (grid_ready_q) begin
          walk_ray_free(gc.rc, gc.rr, gc.tc, gc.tr);
          add_log_odds(gc.tc, gc.tr, int'(occ_inc_q));
        end
      end
      lodg_pkg::CMD_MISS: begin
        if (grid_ready_q && on_grid(gc.rc, gc.rr)) begin
          walk_ray_free(gc.rc, gc.rr, gc.tc, gc.tr);
        end
      end
      lodg_pkg::CMD_FREE: begin
        if (grid_ready_q && on_grid(gc.rc, gc.rr)) begin
          add_log_odds(gc.rc, gc.rr, int'(free_inc_q));
        end
      end
      lodg_pkg::CMD_DECAY: begin
        decay_grid();
      end
      lodg_pkg::CMD_CLEAR: begin
        foreach (grid_q[i]) grid_q[i] = 8'sd0;
        grid_ready_q = 1'b1;
      end
      default: begin
      end
    endcase
    if (cmd_reports.size() == 0) begin
      done_rep = '0;
      cmd_reports.push_back(done_rep);
    end
    cmd_reports[cmd_reports.size() - 1].last = 1'b1;
    foreach (cmd_reports[i]) report_exp_q.push_back(cmd_reports[i]);
  endfunction

  // command driver
  always @(posedge clk) begin : cmd_driver
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_grid_cmd(cur_cmd);
        cmds_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (cmd_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_cmd = cmd_pending_q.pop_front();
          in_valid <= 1'b1;
          command <= cur_cmd.cmd;
          rover_col <= cur_cmd.rc;
          rover_row <= cur_cmd.rr;
          target_col <= cur_cmd.tc;
          target_row <= cur_cmd.tr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin : result_monitor
    lodg_pkg::report_t want;
    lodg_pkg::report_t got;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        got.row = cell_row;
        got.col = cell_col;
        got.value = cell_value;
        got.cls = cell_class;
        got.changed = changed;
        got.last = last;
        if (report_exp_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= SHOW_LIMIT)
            $display("ERROR: result item with none expected: %s %0d %0d %0d %0d %0b %0b",
                     "row col val cls chg last", got.row, got.col, got.value, got.cls,
                     got.changed, got.last);
        end else begin
          want = report_exp_q.pop_front();
          reports_checked++;
          if (got.row !== want.row || got.col !== want.col || got.value !== want.value ||
              got.cls !== want.cls || got.changed !== want.changed || got.last !== want.last) begin
            fail_cnt++;
            if (fail_cnt <= SHOW_LIMIT) begin
              $display("ERROR: result mismatch at cycle %0d", cycle_cnt);
              $display("  expected row %0d col %0d val %0d cls %0d chg %0b last %0b",
                       want.row, want.col, want.value, want.cls, want.changed, want.last);
              $display("  actual   row %0d col %0d val %0d cls %0d chg %0b last %0b",
                       got.row, got.col, got.value, got.cls, got.changed, got.last);
            end
          end
        end
      end
    end
  end

  // cycle counter and watchdog
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("ERROR: timeout after %0d cycles, %0d results still expected",
             cycle_cnt, report_exp_q.size());
    $display("Verification failed");
    $finish;
  end

  task automatic push_cmd(logic [2:0] c, int rc, int rr, int tc, int tr);
    grid_cmd_t gc;
    gc.cmd = c;
    gc.rc = 8'(rc);
    gc.rr = 8'(rr);
    gc.tc = 8'(tc);
    gc.tr = 8'(tr);
    cmd_pending_q.push_back(gc);
  endtask

  task automatic cfg_write(lodg_pkg::cfg_e idx, logic [7:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      lodg_pkg::CFG_OCC_INC:  occ_inc_q = data;
      lodg_pkg::CFG_FREE_INC: free_inc_q = data;
      lodg_pkg::CFG_THR:      thr_q = data[6:0];
      lodg_pkg::CFG_DECAY:    decay_q = data[6:0];
      default: begin
      end
    endcase
    cfg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // write all four registers; unused top bit of 7-bit registers is random
  task automatic cfg_all(int occ, int free_inc, int thr, int dstep);
    cfg_write(lodg_pkg::CFG_OCC_INC, 8'(occ));
    cfg_write(lodg_pkg::CFG_FREE_INC, 8'(free_inc));
    cfg_write(lodg_pkg::CFG_THR, {1'($urandom_range(0, 1)), 7'(thr)});
    cfg_write(lodg_pkg::CFG_DECAY, {1'($urandom_range(0, 1)), 7'(dstep)});
  endtask

  // wait until every item is sent and every result has arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_pending_q.size() != 0 || in_valid || report_exp_q.size() != 0);
  endtask

  task automatic settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly near the grid, sometimes anywhere in the byte range
  function automatic int pick_coord();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, GRID_COLS + 1);
  endfunction

  task automatic queue_random_cmds(int n);
    int sel;
    logic [2:0] c;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) c = lodg_pkg::CMD_HIT;
      else if (sel < 60) c = lodg_pkg::CMD_MISS;
      else if (sel < 72) c = lodg_pkg::CMD_FREE;
      else if (sel < 84) c = lodg_pkg::CMD_DECAY;
      else if (sel < 93) c = lodg_pkg::CMD_CLEAR;
      else c = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      push_cmd(c, pick_coord(), pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  // stimulus sequence
  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    settle();

    // reset settings: grid not ready, then basic rays and corner cases
    push_cmd(lodg_pkg::CMD_HIT, 1, 1, 3, 3);
    push_cmd(lodg_pkg::CMD_MISS, 1, 1, 3, 3);
    push_cmd(lodg_pkg::CMD_FREE, 2, 2, 0, 0);
    push_cmd(lodg_pkg::CMD_DECAY, 0, 0, 0, 0);
    push_cmd(CMD_UNUSED_LO, 0, 0, 0, 0);
    push_cmd(CMD_UNUSED_HI, 255, 255, 255, 255);
    push_cmd(lodg_pkg::CMD_CLEAR, 0, 0, 0, 0);
    push_cmd(lodg_pkg::CMD_HIT, 2, 2, 2, 2);
    push_cmd(lodg_pkg::CMD_HIT, 0, 0, 7, 7);
    push_cmd(lodg_pkg::CMD_HIT, 255, 255, 0, 0);
    push_cmd(lodg_pkg::CMD_MISS, 255, 0, 3, 3);
    push_cmd(lodg_pkg::CMD_MISS, 0, 7, 7, 0);
    push_cmd(lodg_pkg::CMD_FREE, 4, 4, 0, 0);
    push_cmd(lodg_pkg::CMD_FREE, 8, 3, 0, 0);
    push_cmd(lodg_pkg::CMD_HIT, 0, 255, 255, 0);
    push_cmd(lodg_pkg::CMD_DECAY, 0, 0, 0, 0);
    wait_drained();
    settle();

    // extreme increments, zero threshold: fill every row, saturate, then a full decay
    cfg_all(lodg_pkg::CELL_MAX, -lodg_pkg::CELL_MAX, 0, lodg_pkg::CELL_MAX);
    for (int r = 0; r < GRID_ROWS; r++) push_cmd(lodg_pkg::CMD_HIT, 0, r, GRID_COLS - 1, r);
    push_cmd(lodg_pkg::CMD_HIT, 0, 0, GRID_COLS - 1, 0);
    push_cmd(lodg_pkg::CMD_DECAY, 0, 0, 0, 0);
    wait_drained();
    settle();

    // random phases under several settings and idle patterns
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 27;
        recv_stall_pct = 76;
      end else if (ph < 4) begin
        send_idle_pct = 76;
        recv_stall_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      case (ph)
        0: cfg_all(40, -30, 20, 10);
        1: cfg_all(-lodg_pkg::CELL_MAX, lodg_pkg::CELL_MAX, lodg_pkg::CELL_MAX, 0);
        3: cfg_all(lodg_pkg::CELL_MAX, -lodg_pkg::CELL_MAX, 0, lodg_pkg::CELL_MAX);
        default: cfg_all($urandom_range(0, 2 * lodg_pkg::CELL_MAX) - lodg_pkg::CELL_MAX,
                         $urandom_range(0, 2 * lodg_pkg::CELL_MAX) - lodg_pkg::CELL_MAX,
                         $urandom_range(0, lodg_pkg::CELL_MAX),
                         $urandom_range(0, lodg_pkg::CELL_MAX));
      endcase
      push_cmd(lodg_pkg::CMD_CLEAR, 0, 0, 0, 0);
      queue_random_cmds(RANDOM_PER_PHASE);
      wait_drained();
      settle();
    end

    if (report_exp_q.size() != 0) fail_cnt++;
    $display("run covered %0d commands and %0d checked result items over %0d register writes",
             cmds_accepted, reports_checked, cfg_writes);
    $display("directed corner cases plus %0d random phases, %0d failures",
             RANDOM_PHASES, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
